// ===== sv/gclp_pkg.sv =====
// ----------------------------------------------------------------------------
// gclp_pkg
// shared types, codes and constants of the g-code line word parser
// ----------------------------------------------------------------------------
package gclp_pkg;

  typedef enum logic [3:0] {
    PH_LEAD, PH_CMDNUM, PH_BODY, PH_CMD_DONE, PH_BANG,
    PH_BANG_DONE, PH_HELPM, PH_HELP_OK, PH_ERR, PH_DISCARD
  } phase_e;

  typedef enum logic [3:0] {
    OW_NONE, OW_X, OW_Y, OW_Z, OW_T1, OW_T2, OW_T3, OW_F, OW_S, OW_TPEND
  } word_e;

  typedef enum logic [1:0] {
    ST_PARSED   = 2'd0,
    ST_ERROR    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_G    = 2'd1,
    CMD_M    = 2'd2,
    CMD_HELP = 2'd3
  } cmd_e;

  localparam logic [3:0] KIND_HEADER = 4'd0;
  localparam logic [7:0] LINE_LIMIT_RESET = 8'd128;
  localparam logic [7:0] BANG_NUMBER = 8'd112;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef struct packed {
    status_e    status;
    cmd_e       cmd;
    logic       has_num;
    logic [7:0] present;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] r;
    unique case (n)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] help_char(input logic [2:0] n);
    logic [7:0] r;
    unique case (n)
      3'd1:    r = CH_E;
      3'd2:    r = CH_L;
      3'd3:    r = CH_P;
      default: r = CH_H;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/gclp_fifo.sv =====
// ----------------------------------------------------------------------------
// gclp_fifo
// two-entry queue of line records between the parser front and the emitter
// ----------------------------------------------------------------------------
module gclp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== sv/gclp_front.sv =====
// ----------------------------------------------------------------------------
// gclp_front
// per-byte line parser; hands a finished line record to the queue
// ----------------------------------------------------------------------------
module gclp_front #(
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_BITS  = 32,
  parameter int NUMBER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     line_limit_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           full_i,
  output logic                           push_o,
  output gclp_pkg::hdr_t                 hdr_o,
  output logic [NUMBER_BITS-1:0]         num_o,
  output logic [7:0][VALUE_BITS-1:0]     vals_o
);

  localparam int SW = (VALUE_BITS > 24 ? VALUE_BITS : 24) + 2;
  localparam logic [SW-1:0] CAP = SW'(1) << (VALUE_BITS - 1);
  localparam logic [SW-1:0] CAP_DIV10 = CAP / 10;
  localparam logic [2:0] FD = 3'(FRAC_DIGITS);
  localparam logic [NUMBER_BITS+3:0] NUM_MAX = (NUMBER_BITS+4)'({NUMBER_BITS{1'b1}});

  gclp_pkg::phase_e              phase_q, phase_d;
  gclp_pkg::word_e               ow_q, ow_d;
  gclp_pkg::cmd_e                cmd_q, cmd_d;
  logic [7:0]                    count_q, count_d;
  logic [NUMBER_BITS-1:0]        num_q, num_d;
  logic                          seen_q, seen_d;
  logic [VALUE_BITS-1:0]         acc_q, acc_d;
  logic                          neg_q, neg_d, frac_q, frac_d, stop_q, stop_d;
  logic                          started_q, started_d;
  logic [2:0]                    fcnt_q, fcnt_d;
  logic [7:0]                    present_q, present_d;
  logic [2:0]                    alias_q, alias_d;
  logic [7:0][VALUE_BITS-1:0]    store_q;
  logic                          st_we;
  logic [2:0]                    st_idx;

  logic [7:0]                    c;
  logic                          eol, is_dig, is_ws, accept, need_push, body_done;
  logic                          ow_val, close_ok;
  logic [VALUE_BITS-1:0]         close_v;
  logic [3:0]                    dig;
  logic [SW-1:0]                 acc_x, m, add, sum;
  logic [NUMBER_BITS+3:0]        nv;

  assign eol    = in_byte_i == gclp_pkg::CH_LF || in_byte_i == gclp_pkg::CH_CR;
  assign c      = (in_byte_i >= gclp_pkg::CH_LA && in_byte_i <= gclp_pkg::CH_LZ) ?
                  in_byte_i - 8'd32 : in_byte_i;
  assign is_dig = c >= gclp_pkg::CH_0 && c <= gclp_pkg::CH_9;
  assign is_ws  = c == gclp_pkg::CH_SPACE || c == gclp_pkg::CH_TAB ||
                  c == gclp_pkg::CH_VT || c == gclp_pkg::CH_FF;
  assign dig    = 4'(c - gclp_pkg::CH_0);

  assign need_push = eol ? (phase_q != gclp_pkg::PH_DISCARD &&
                            !(phase_q == gclp_pkg::PH_LEAD && count_q == 8'd0))
                         : (phase_q != gclp_pkg::PH_DISCARD && count_q >= line_limit_i);
  assign in_ready_o = !full_i || !need_push;
  assign accept     = in_valid_i && in_ready_o;

  assign ow_val   = ow_q >= gclp_pkg::OW_X && ow_q <= gclp_pkg::OW_S;
  assign close_ok = ow_val && (started_q ||
                    (ow_q >= gclp_pkg::OW_T1 && ow_q <= gclp_pkg::OW_T3));
  assign close_v  = neg_q ? (VALUE_BITS)'(-acc_q) :
                    ((SW'(acc_q) >= CAP) ? (VALUE_BITS)'(CAP - SW'(1)) : acc_q);
  assign st_idx   = 3'(ow_q - gclp_pkg::OW_X);

  // value digit arithmetic
  always_comb begin
    acc_x = SW'(acc_q);
    if (!frac_q) begin
      m   = (acc_x > CAP_DIV10) ? CAP : (acc_x << 3) + (acc_x << 1);
      add = SW'(dig * gclp_pkg::pow10(FD));
    end else begin
      m   = acc_x;
      add = SW'(dig * gclp_pkg::pow10(FD - fcnt_q - 3'd1));
    end
    sum = m + add;
    if (sum > CAP) sum = CAP;
  end

  assign nv = (NUMBER_BITS+4)'(num_q) * (NUMBER_BITS+4)'(10) + (NUMBER_BITS+4)'(dig);

  always_comb begin
    phase_d   = phase_q;
    ow_d      = ow_q;
    cmd_d     = cmd_q;
    count_d   = count_q;
    num_d     = num_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    frac_d    = frac_q;
    stop_d    = stop_q;
    started_d = started_q;
    fcnt_d    = fcnt_q;
    present_d = present_q;
    alias_d   = alias_q;
    st_we     = 1'b0;
    body_done = 1'b0;
    push_o    = 1'b0;
    hdr_o     = '{status: gclp_pkg::ST_ERROR, cmd: gclp_pkg::CMD_NONE,
                  has_num: 1'b0, present: 8'd0};
    num_o     = '0;
    vals_o    = store_q;
    if (accept) begin
      if (eol || (phase_q != gclp_pkg::PH_DISCARD && count_q >= line_limit_i)) begin
        push_o = need_push;
        if (!eol) begin
          hdr_o.status = gclp_pkg::ST_TOO_LONG;
        end else begin
          unique case (phase_q)
            gclp_pkg::PH_CMDNUM, gclp_pkg::PH_BODY, gclp_pkg::PH_CMD_DONE: begin
              hdr_o.status  = gclp_pkg::ST_PARSED;
              hdr_o.cmd     = cmd_q;
              hdr_o.has_num = seen_q;
              hdr_o.present = present_q;
              num_o         = num_q;
              if (close_ok) begin
                hdr_o.present[st_idx] = 1'b1;
                vals_o[st_idx]        = close_v;
              end
            end
            gclp_pkg::PH_BANG, gclp_pkg::PH_BANG_DONE: begin
              hdr_o.status  = gclp_pkg::ST_PARSED;
              hdr_o.cmd     = gclp_pkg::CMD_M;
              hdr_o.has_num = 1'b1;
              num_o         = NUMBER_BITS'(gclp_pkg::BANG_NUMBER);
            end
            gclp_pkg::PH_HELP_OK: begin
              hdr_o.status = gclp_pkg::ST_PARSED;
              hdr_o.cmd    = gclp_pkg::CMD_HELP;
            end
            default: begin
            end
          endcase
        end
        count_d   = 8'd0;
        phase_d   = eol ? gclp_pkg::PH_LEAD : gclp_pkg::PH_DISCARD;
        cmd_d     = gclp_pkg::CMD_NONE;
        num_d     = '0;
        seen_d    = 1'b0;
        present_d = 8'd0;
        alias_d   = 3'd0;
        ow_d      = gclp_pkg::OW_NONE;
        acc_d     = '0;
        neg_d     = 1'b0;
        frac_d    = 1'b0;
        stop_d    = 1'b0;
        started_d = 1'b0;
        fcnt_d    = 3'd0;
      end else if (phase_q != gclp_pkg::PH_DISCARD) begin
        count_d = count_q + 8'd1;
        unique case (phase_q)
          gclp_pkg::PH_LEAD: begin
            if (!is_ws) begin
              priority if (c == gclp_pkg::CH_G) begin
                cmd_d = gclp_pkg::CMD_G;
                phase_d = gclp_pkg::PH_CMDNUM;
              end else if (c == gclp_pkg::CH_M) begin
                cmd_d = gclp_pkg::CMD_M;
                phase_d = gclp_pkg::PH_CMDNUM;
              end else if (c == gclp_pkg::CH_BANG) begin
                phase_d = gclp_pkg::PH_BANG;
              end else if (c == gclp_pkg::CH_H) begin
                alias_d = 3'd1;
                phase_d = gclp_pkg::PH_HELPM;
              end else begin
                phase_d = gclp_pkg::PH_ERR;
              end
            end
          end
          gclp_pkg::PH_CMDNUM, gclp_pkg::PH_BODY: begin
            if (phase_q == gclp_pkg::PH_CMDNUM && is_dig) begin
              num_d  = (nv > NUM_MAX) ? NUMBER_BITS'(NUM_MAX) : NUMBER_BITS'(nv);
              seen_d = 1'b1;
            end else begin
              phase_d = gclp_pkg::PH_BODY;
              if (ow_q == gclp_pkg::OW_TPEND) begin
                ow_d = gclp_pkg::OW_NONE;
                if (is_dig) begin
                  body_done = 1'b1;
                  if (c >= gclp_pkg::CH_1 && c <= gclp_pkg::CH_3) begin
                    ow_d = gclp_pkg::word_e'(4'(gclp_pkg::OW_T1) + 4'(c - gclp_pkg::CH_1));
                  end
                end
              end else if (ow_val) begin
                if (is_dig || c == gclp_pkg::CH_DOT || c == gclp_pkg::CH_MINUS) begin
                  body_done = 1'b1;
                  if (!stop_q) begin
                    priority if (c == gclp_pkg::CH_MINUS) begin
                      if (started_q) stop_d = 1'b1;
                      else neg_d = 1'b1;
                    end else if (c == gclp_pkg::CH_DOT) begin
                      if (frac_q) stop_d = 1'b1;
                      else frac_d = 1'b1;
                    end else if (!frac_q) begin
                      acc_d = VALUE_BITS'(sum);
                    end else if (fcnt_q < FD) begin
                      fcnt_d = fcnt_q + 3'd1;
                      acc_d  = VALUE_BITS'(sum);
                    end
                  end
                  started_d = 1'b1;
                end else if (close_ok) begin
                  st_we = 1'b1;
                  present_d[st_idx] = 1'b1;
                end
              end
              if (!body_done) begin
                acc_d     = '0;
                neg_d     = 1'b0;
                frac_d    = 1'b0;
                stop_d    = 1'b0;
                started_d = 1'b0;
                fcnt_d    = 3'd0;
                priority case (c)
                  gclp_pkg::CH_X:                ow_d = gclp_pkg::OW_X;
                  gclp_pkg::CH_Y:                ow_d = gclp_pkg::OW_Y;
                  gclp_pkg::CH_Z:                ow_d = gclp_pkg::OW_Z;
                  gclp_pkg::CH_F, gclp_pkg::CH_P: ow_d = gclp_pkg::OW_F;
                  gclp_pkg::CH_S:                ow_d = gclp_pkg::OW_S;
                  gclp_pkg::CH_T:                ow_d = gclp_pkg::OW_TPEND;
                  gclp_pkg::CH_SEMI: begin
                    ow_d    = gclp_pkg::OW_NONE;
                    phase_d = gclp_pkg::PH_CMD_DONE;
                  end
                  default:                       ow_d = gclp_pkg::OW_NONE;
                endcase
              end
            end
          end
          gclp_pkg::PH_BANG: begin
            if (c == gclp_pkg::CH_SEMI) phase_d = gclp_pkg::PH_BANG_DONE;
            else if (!is_ws) phase_d = gclp_pkg::PH_ERR;
          end
          gclp_pkg::PH_HELPM: begin
            if (alias_q < 3'd4 && c == gclp_pkg::help_char(alias_q)) begin
              alias_d = alias_q + 3'd1;
              if (alias_q == 3'd3) phase_d = gclp_pkg::PH_HELP_OK;
            end else begin
              phase_d = gclp_pkg::PH_ERR;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_q[st_idx] <= close_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= gclp_pkg::PH_LEAD;
      ow_q      <= gclp_pkg::OW_NONE;
      cmd_q     <= gclp_pkg::CMD_NONE;
      count_q   <= 8'd0;
      num_q     <= '0;
      seen_q    <= 1'b0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      frac_q    <= 1'b0;
      stop_q    <= 1'b0;
      started_q <= 1'b0;
      fcnt_q    <= 3'd0;
      present_q <= 8'd0;
      alias_q   <= 3'd0;
    end else begin
      phase_q   <= phase_d;
      ow_q      <= ow_d;
      cmd_q     <= cmd_d;
      count_q   <= count_d;
      num_q     <= num_d;
      seen_q    <= seen_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      frac_q    <= frac_d;
      stop_q    <= stop_d;
      started_q <= started_d;
      fcnt_q    <= fcnt_d;
      present_q <= present_d;
      alias_q   <= alias_d;
    end
  end

endmodule

// ===== sv/gclp_back.sv =====
// ----------------------------------------------------------------------------
// gclp_back
// walks one line record and sends header and word results through an
// output register
// ----------------------------------------------------------------------------
module gclp_back #(
  parameter int VALUE_BITS  = 32,
  parameter int NUMBER_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  gclp_pkg::hdr_t             hdr_i,
  input  logic [NUMBER_BITS-1:0]     num_i,
  input  logic [7:0][VALUE_BITS-1:0] vals_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [3:0]                 result_kind_o,
  output logic [1:0]                 status_o,
  output logic [1:0]                 command_o,
  output logic [NUMBER_BITS-1:0]     command_number_o,
  output logic                       has_number_o,
  output logic [VALUE_BITS-1:0]      word_value_o,
  output logic                       last_o
);

  logic                   vld_q, vld_d, hdr_sent_q, hdr_sent_d;
  logic [7:0]             mask_q, mask_d, mask_nx;
  logic [3:0]             kind_q, kind_d;
  logic [1:0]             status_q, status_d, cmd_q, cmd_d;
  logic [NUMBER_BITS-1:0] num_q, num_d;
  logic                   hasn_q, hasn_d, last_q, last_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [2:0]             idx;

  always_comb begin
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_q[i]) idx = 3'(i);
    end
    mask_nx = mask_q & ~(8'd1 << idx);
  end

  always_comb begin
    vld_d      = vld_q && !out_ready_i;
    hdr_sent_d = hdr_sent_q;
    mask_d     = mask_q;
    kind_d     = kind_q;
    status_d   = status_q;
    cmd_d      = cmd_q;
    num_d      = num_q;
    hasn_d     = hasn_q;
    last_d     = last_q;
    val_d      = val_q;
    pop_o      = 1'b0;
    if (head_valid_i && (!vld_q || out_ready_i)) begin
      vld_d = 1'b1;
      if (!hdr_sent_q) begin
        kind_d   = gclp_pkg::KIND_HEADER;
        status_d = hdr_i.status;
        cmd_d    = hdr_i.cmd;
        num_d    = num_i;
        hasn_d   = hdr_i.has_num;
        val_d    = '0;
        last_d   = hdr_i.present == 8'd0;
        if (hdr_i.present == 8'd0) begin
          pop_o = 1'b1;
        end else begin
          hdr_sent_d = 1'b1;
          mask_d     = hdr_i.present;
        end
      end else begin
        kind_d   = {1'b0, idx} + 4'd1;
        status_d = gclp_pkg::ST_PARSED;
        cmd_d    = gclp_pkg::CMD_NONE;
        num_d    = '0;
        hasn_d   = 1'b0;
        val_d    = vals_i[idx];
        last_d   = mask_nx == 8'd0;
        mask_d   = mask_nx;
        if (mask_nx == 8'd0) begin
          pop_o      = 1'b1;
          hdr_sent_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    cmd_q    <= cmd_d;
    num_q    <= num_d;
    hasn_q   <= hasn_d;
    last_q   <= last_d;
    val_q    <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      hdr_sent_q <= 1'b0;
      mask_q     <= 8'd0;
    end else begin
      vld_q      <= vld_d;
      hdr_sent_q <= hdr_sent_d;
      mask_q     <= mask_d;
    end
  end

  assign out_valid_o      = vld_q;
  assign result_kind_o    = kind_q;
  assign status_o         = status_q;
  assign command_o        = cmd_q;
  assign command_number_o = num_q;
  assign has_number_o     = hasn_q;
  assign word_value_o     = val_q;
  assign last_o           = last_q;

endmodule

// ===== sv/gcode_line_word_parser.sv =====
// ----------------------------------------------------------------------------
// gcode_line_word_parser
// g-code line parser: bytes in, header and word results out
// ----------------------------------------------------------------------------
// input channel: one byte per word on in_valid_i/in_ready_o; ordinary bytes
// are taken every cycle. a CR/LF or a byte overrunning the line limit
// needs a free slot in the two-entry line queue, else ready drops.
// output channel: out_valid_o/out_ready_i, one result per word from an
// output register; per line a header, then one word result per present
// word in kind order, last_o on the final one.
// a line end's record enters the queue on the accepting edge and its header
// then passes the output register; the emitter sends one result per cycle
// while out_ready_i is high. input takes one byte per cycle while the queue
// has room at line ends; n words give n+1 results, overlapped with new bytes.
// cfg_we_i writes the line limit (reset 128); write only while idle.
// reset clears the parse state (not the stored word values), the queue and the output valid.
// a stalled receiver holds the output; the queue fills and then ready
// drops at the next line end, while ordinary bytes keep flowing.
// ----------------------------------------------------------------------------
module gcode_line_word_parser #(
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_BITS  = 32,
  parameter int NUMBER_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             in_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             result_kind_o,
  output logic [1:0]             status_o,
  output logic [1:0]             command_o,
  output logic [NUMBER_BITS-1:0] command_number_o,
  output logic                   has_number_o,
  output logic [VALUE_BITS-1:0]  word_value_o,
  output logic                   last_o
);

  localparam int REC_W = gclp_pkg::HDR_W + NUMBER_BITS + 8 * VALUE_BITS;

  logic [7:0]                 limit_q;
  logic                       push, pop, full, head_valid;
  gclp_pkg::hdr_t             f_hdr, h_hdr;
  logic [NUMBER_BITS-1:0]     f_num, h_num;
  logic [7:0][VALUE_BITS-1:0] f_vals, h_vals;
  logic [REC_W-1:0]           head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= gclp_pkg::LINE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  gclp_front #(
    .FRAC_DIGITS (FRAC_DIGITS),
    .VALUE_BITS  (VALUE_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_limit_i (limit_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .full_i       (full),
    .push_o       (push),
    .hdr_o        (f_hdr),
    .num_o        (f_num),
    .vals_o       (f_vals)
  );

  gclp_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_hdr, f_num, f_vals}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  assign {h_hdr, h_num, h_vals} = head;

  gclp_back #(
    .VALUE_BITS  (VALUE_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .hdr_i            (h_hdr),
    .num_i            (h_num),
    .vals_i           (h_vals),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .status_o         (status_o),
    .command_o        (command_o),
    .command_number_o (command_number_o),
    .has_number_o     (has_number_o),
    .word_value_o     (word_value_o),
    .last_o           (last_o)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("line queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty line queue");

  a_word_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != gclp_pkg::KIND_HEADER |->
      status_o == gclp_pkg::ST_PARSED && command_o == gclp_pkg::CMD_NONE)
    else $error("word result with header fields");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != gclp_pkg::ST_PARSED |-> last_o)
    else $error("error header not last");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// testbench of the g-code line word parser: directed and random lines go in
// byte by byte, a predictor builds the expected header and word results and
// a scoreboard checks every result in order, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  kind;
    logic [1:0]  status;
    logic [1:0]  cmd;
    logic [15:0] num;
    logic        hasn;
    logic [31:0] value;
    logic        last;
  } res_t;

  class gcode_scoreboard;
    res_t              pending_q[$];
    int                errors;
    int                checked;
    logic [7:0]        limit;
    logic [7:0]        count;
    gclp_pkg::phase_e  phase;
    gclp_pkg::cmd_e    code;
    logic [15:0]       cnum;
    logic              cseen;
    gclp_pkg::word_e   word;
    logic [63:0]       acc;
    logic              neg, frac, stop, started;
    int                fcnt;
    logic [31:0]       store[8];
    logic [7:0]        present;
    int                hmatch;

    function new();
      limit = gclp_pkg::LINE_LIMIT_RESET;
      errors = 0;
      checked = 0;
      clear_line();
    endfunction

    function void clear_word();
      word = gclp_pkg::OW_NONE;
      acc = 0;
      neg = 0; frac = 0; stop = 0; started = 0;
      fcnt = 0;
    endfunction

    function void clear_line();
      count = 0;
      phase = gclp_pkg::PH_LEAD;
      code = gclp_pkg::CMD_NONE;
      cnum = 0;
      cseen = 0;
      present = 0;
      hmatch = 0;
      clear_word();
    endfunction

    function void push(logic [3:0] k, gclp_pkg::status_e s, gclp_pkg::cmd_e c,
                       logic [15:0] n, logic h, logic [31:0] v, logic l);
      res_t r;
      r.kind = k; r.status = s; r.cmd = c; r.num = n; r.hasn = h; r.value = v;
      r.last = l;
      pending_q.push_back(r);
    endfunction

    function logic [63:0] sat_sum(logic [63:0] m, logic [63:0] a);
      logic [63:0] cap;
      cap = 64'h8000_0000;
      if (m > cap) m = cap;
      m = m + a;
      return (m > cap) ? cap : m;
    endfunction

    function void feed_digit(logic [7:0] c);
      logic [63:0] cap;
      logic [63:0] d;
      cap = 64'h8000_0000;
      if (!stop) begin
        if (c == gclp_pkg::CH_MINUS) begin
          if (started) stop = 1; else neg = 1;
        end else if (c == gclp_pkg::CH_DOT) begin
          if (frac) stop = 1; else frac = 1;
        end else begin
          d = c - gclp_pkg::CH_0;
          if (!frac) begin
            acc = (acc > cap / 10) ? cap : acc * 10;
            acc = sat_sum(acc, d * 1000);
          end else if (fcnt < 3) begin
            fcnt++;
            acc = sat_sum(acc, d * (fcnt == 1 ? 100 : fcnt == 2 ? 10 : 1));
          end
        end
      end
      started = 1;
    endfunction

    function void close_word();
      logic [63:0] cap;
      cap = 64'h8000_0000;
      if (word >= gclp_pkg::OW_X && word <= gclp_pkg::OW_S &&
          (started || (word >= gclp_pkg::OW_T1 && word <= gclp_pkg::OW_T3)))
      begin
        store[word - 1] = neg ? 32'(64'd0 - acc) : 32'(acc >= cap ? cap - 1 : acc);
        present[word - 1] = 1'b1;
      end
      clear_word();
    endfunction

    function void body_byte(logic [7:0] c);
      logic dig;
      dig = c >= gclp_pkg::CH_0 && c <= gclp_pkg::CH_9;
      if (word == gclp_pkg::OW_TPEND) begin
        word = gclp_pkg::OW_NONE;
        if (dig) begin
          if (c >= gclp_pkg::CH_1 && c <= gclp_pkg::CH_3) begin
            clear_word();
            word = gclp_pkg::word_e'(gclp_pkg::OW_T1 + (c - gclp_pkg::CH_1));
          end
          return;
        end
      end else if (word >= gclp_pkg::OW_X && word <= gclp_pkg::OW_S) begin
        if (dig || c == gclp_pkg::CH_DOT || c == gclp_pkg::CH_MINUS) begin
          feed_digit(c);
          return;
        end
        close_word();
      end
      clear_word();
      case (c)
        gclp_pkg::CH_X: word = gclp_pkg::OW_X;
        gclp_pkg::CH_Y: word = gclp_pkg::OW_Y;
        gclp_pkg::CH_Z: word = gclp_pkg::OW_Z;
        gclp_pkg::CH_F, gclp_pkg::CH_P: word = gclp_pkg::OW_F;
        gclp_pkg::CH_S: word = gclp_pkg::OW_S;
        gclp_pkg::CH_T: word = gclp_pkg::OW_TPEND;
        gclp_pkg::CH_SEMI: phase = gclp_pkg::PH_CMD_DONE;
        default: ;
      endcase
    endfunction

    function void end_line();
      case (phase)
        gclp_pkg::PH_DISCARD: ;
        gclp_pkg::PH_LEAD:
          if (count != 0)
            push(gclp_pkg::KIND_HEADER, gclp_pkg::ST_ERROR, gclp_pkg::CMD_NONE,
                 0, 0, 0, 1);
        gclp_pkg::PH_CMDNUM, gclp_pkg::PH_BODY, gclp_pkg::PH_CMD_DONE: begin
          close_word();
          push(gclp_pkg::KIND_HEADER, gclp_pkg::ST_PARSED, code, cnum, cseen, 0,
               present == 0);
          for (int i = 0; i < 8; i++)
            if (present[i])
              push(4'(i + 1), gclp_pkg::ST_PARSED, gclp_pkg::CMD_NONE, 0, 0, store[i],
                   (present >> (i + 1)) == 0);
        end
        gclp_pkg::PH_BANG, gclp_pkg::PH_BANG_DONE:
          push(gclp_pkg::KIND_HEADER, gclp_pkg::ST_PARSED, gclp_pkg::CMD_M,
               gclp_pkg::BANG_NUMBER, 1, 0, 1);
        gclp_pkg::PH_HELP_OK:
          push(gclp_pkg::KIND_HEADER, gclp_pkg::ST_PARSED, gclp_pkg::CMD_HELP,
               0, 0, 0, 1);
        default:
          push(gclp_pkg::KIND_HEADER, gclp_pkg::ST_ERROR, gclp_pkg::CMD_NONE,
               0, 0, 0, 1);
      endcase
      clear_line();
    endfunction

    function void note_byte(logic [7:0] c);
      logic ws;
      logic [19:0] v;
      if (c == gclp_pkg::CH_LF || c == gclp_pkg::CH_CR) begin
        end_line();
        return;
      end
      if (phase == gclp_pkg::PH_DISCARD) return;
      if (count >= limit) begin
        push(gclp_pkg::KIND_HEADER, gclp_pkg::ST_TOO_LONG, gclp_pkg::CMD_NONE,
             0, 0, 0, 1);
        clear_line();
        phase = gclp_pkg::PH_DISCARD;
        return;
      end
      count++;
      if (c >= gclp_pkg::CH_LA && c <= gclp_pkg::CH_LZ) c = c - 8'd32;
      ws = c == gclp_pkg::CH_SPACE || c == gclp_pkg::CH_TAB ||
           c == gclp_pkg::CH_VT || c == gclp_pkg::CH_FF;
      case (phase)
        gclp_pkg::PH_LEAD: begin
          if (!ws) begin
            if (c == gclp_pkg::CH_G) begin
              code = gclp_pkg::CMD_G; phase = gclp_pkg::PH_CMDNUM;
            end else if (c == gclp_pkg::CH_M) begin
              code = gclp_pkg::CMD_M; phase = gclp_pkg::PH_CMDNUM;
            end else if (c == gclp_pkg::CH_BANG) phase = gclp_pkg::PH_BANG;
            else if (c == gclp_pkg::CH_H) begin
              hmatch = 1; phase = gclp_pkg::PH_HELPM;
            end else phase = gclp_pkg::PH_ERR;
          end
        end
        gclp_pkg::PH_CMDNUM: begin
          if (c >= gclp_pkg::CH_0 && c <= gclp_pkg::CH_9) begin
            v = 20'(cnum) * 20'd10 + 20'(c - gclp_pkg::CH_0);
            cnum = (v > 20'hFFFF) ? 16'hFFFF : v[15:0];
            cseen = 1;
          end else begin
            phase = gclp_pkg::PH_BODY;
            body_byte(c);
          end
        end
        gclp_pkg::PH_BODY: body_byte(c);
        gclp_pkg::PH_BANG: begin
          if (c == gclp_pkg::CH_SEMI) phase = gclp_pkg::PH_BANG_DONE;
          else if (!ws) phase = gclp_pkg::PH_ERR;
        end
        gclp_pkg::PH_HELPM: begin
          if (hmatch < 4 && c == gclp_pkg::help_char(3'(hmatch))) begin
            hmatch++;
            if (hmatch == 4) phase = gclp_pkg::PH_HELP_OK;
          end else phase = gclp_pkg::PH_ERR;
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind %0d", a.kind);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.kind !== e.kind) begin
        $error("result_kind exp %0d got %0d", e.kind, a.kind); errors++;
      end
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.cmd !== e.cmd) begin
        $error("command exp %0d got %0d", e.cmd, a.cmd); errors++;
      end
      if (a.num !== e.num) begin
        $error("command_number exp %0d got %0d", e.num, a.num); errors++;
      end
      if (a.hasn !== e.hasn) begin
        $error("has_number exp %0d got %0d", e.hasn, a.hasn); errors++;
      end
      if (a.value !== e.value) begin
        $error("word_value exp %0h got %0h", e.value, a.value); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [7:0]  cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [3:0]  result_kind_o;
  logic [1:0]  status_o;
  logic [1:0]  command_o;
  logic [15:0] command_number_o;
  logic        has_number_o;
  logic [31:0] word_value_o;
  logic        last_o;

  gcode_line_word_parser u_top (.*);

  always #6 clk_i = ~clk_i;

  gcode_scoreboard sb = new();
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  bit  hold_rx = 0;
  bit  done = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // monitor and watchdog
  always @(posedge clk_i) begin
    res_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        r.kind = result_kind_o; r.status = status_o; r.cmd = command_o;
        r.num = command_number_o; r.hasn = has_number_o; r.value = word_value_o;
        r.last = last_o;
        sb.check_result(r);
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) || hold_rx || done)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("timeout");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) out_ready_i <= 0;
      else if (out_ready_i && out_valid_o) begin
        g = gap_len();
        if (g > 0) begin
          out_ready_i <= 0;
          repeat (g) @(negedge clk_i);
          out_ready_i <= 1;
        end
      end else out_ready_i <= ($urandom_range(0, 9) != 0);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic set_limit(logic [7:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.limit = v;
  endtask

  function automatic string rand_num();
    string s;
    int n;
    s = ($urandom_range(0, 3) == 0) ? "-" : "";
    n = $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) n = 12;
    for (int i = 0; i < n; i++)
      s = {s, string'(8'(gclp_pkg::CH_0 + $urandom_range(0, 9)))};
    if ($urandom_range(0, 1)) begin
      s = {s, "."};
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++)
        s = {s, string'(8'(gclp_pkg::CH_0 + $urandom_range(0, 9)))};
    end
    if ($urandom_range(0, 15) == 0) s = {s, "-3.2.1"};
    return s;
  endfunction

  function automatic string rand_line();
    string s;
    string letters;
    int r;
    letters = "XYZFPSxyzfpsTT";
    r = $urandom_range(0, 99);
    if (r < 8) begin
      s = "";
      for (int i = $urandom_range(1, 10); i > 0; i--) s = {s, string'(8'($urandom))};
      return {s, "\n"};
    end
    if (r < 12) return ($urandom_range(0, 1)) ? "help\n" : "HELx\n";
    if (r < 15) return ($urandom_range(0, 1)) ? "  ! ;x\r" : "!a\n";
    s = $urandom_range(0, 1) ? "G" : "m";
    if ($urandom_range(0, 4) == 0) s = {" \t", s};
    for (int i = $urandom_range(0, 3); i > 0; i--)
      s = {s, string'(8'(gclp_pkg::CH_0 + $urandom_range(0, 9)))};
    for (int i = $urandom_range(0, 6); i > 0; i--) begin
      r = $urandom_range(0, letters.len() - 1);
      s = {s, ($urandom_range(0, 1)) ? " " : ""};
      if (letters[r] == "T")
        s = {s, "T", string'(8'(gclp_pkg::CH_0 + $urandom_range(0, 9)))};
      else s = {s, string'(letters[r]), rand_num()};
    end
    if ($urandom_range(0, 5) == 0) s = {s, " ;c X5"};
    return {s, ($urandom_range(0, 1)) ? "\n" : "\r"};
  endfunction

  initial begin
    in_valid_i = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed
    send_line("\n\r   \n;only\n");
    send_line("G1 X1.5 Y-2.25 Z0.0004 F300 S99999999999\n");
    send_line("m999999 t1 T2-3 T3 P7 f8 T4 T x--1 y1..5 Z\n");
    send_line("G X Y\r!\n  ! ;c\n!x\nHELP me\nhelq\nQ1 X5\n");
    send_byte(8'hFF); send_byte(8'h80); send_byte(8'h00); send_line("\n");
    send_line("M-2147483.648 X-9999999\n");
    drain();
    set_limit(8'd1);
    send_line("G\nG1\nX\n");
    drain();
    set_limit(8'd24);
    for (int i = 0; i < 30; i++) send_byte(" ");
    send_line("\nG0 X1\n");
    drain();
    set_limit(8'd0);
    send_line("G1\n\n");
    drain();
    set_limit(8'd20);
    // long receiver hold while bytes keep coming
    fork
      begin
        hold_rx = 1;
        repeat (200) @(negedge clk_i);
        hold_rx = 0;
      end
    join_none
    for (int i = 0; i < 4; i++) send_line("G1 X1 Y2 Z3\n");
    drain();
    set_limit(gclp_pkg::LINE_LIMIT_RESET);

    // random
    while (bytes_sent < 320) begin
      send_line(rand_line());
      if ($urandom_range(0, 30) == 0) begin
        drain();
        set_limit(8'($urandom_range(4, 255)));
      end
    end
    drain();
    repeat (20) @(negedge clk_i);
    done = 1;
    $display("sent %0d bytes over several line limits, checked %0d results",
             bytes_sent, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
